// ===== src/kmb_pkg.sv =====
// Shared types and constants for the k-mer minimiser bucketing unit.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps

package kmb_pkg;

  // Widths that the interface fixes.
  localparam int KMER_OUT_W = 62;
  localparam int MINI_OUT_W = 26;
  localparam int BUCKET_W   = 20;
  localparam int OFF_W      = 5;

  // Odd multiplier of the invertible mixing hash, split into 32-bit halves.
  localparam logic [63:0] MIX_MUL    = 64'hD6E8FEB86659FD93;
  localparam logic [31:0] MIX_MUL_LO = MIX_MUL[31:0];
  localparam logic [31:0] MIX_MUL_HI = MIX_MUL[63:32];

  // Depth of the queue between front and back (a power of two).
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);

  // Request on the input channel.
  typedef struct packed {
    logic [6:0] symbol;
    logic       read_end;
  } in_item_t;

  // Request on the result channel.
  typedef struct packed {
    logic [KMER_OUT_W-1:0] kmer_fwd;
    logic [KMER_OUT_W-1:0] kmer_revcomp;
    logic [BUCKET_W-1:0]   bucket;
    logic [MINI_OUT_W-1:0] minimizer;
    logic                  new_group;
    logic                  last;
  } out_item_t;

  // One k-mer handed from the front to the back, windows zero-extended.
  typedef struct packed {
    logic [63:0] fwd_win;
    logic [63:0] rc_win;
    logic [63:0] fwd_mmer;
    logic [63:0] rc_mmer;
    logic        first;
    logic        last;
  } entry_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic not_empty;
    logic full;
  } q_stat_t;

  // Hash unit handshake.
  typedef struct packed {
    logic        start;
    logic [63:0] key;
  } hash_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] value;
  } hash_rsp_t;

endpackage

// ===== src/kmer_minimizer_bucketing_unit.sv =====
// A result follows its base through the front, the queue and the back: the back hashes the
// newest m-mer when the minimiser stays or a newer m-mer takes over, and hashes every m-mer
// position (KMER_LEN - MINI_LEN + 1 positions) for the first k-mer of a read and for a rescan.
// The back takes a new k-mer only when done with the last, paced by the iterative hash unit;
// bases short of a full k-mer are taken by the front without queueing while the queue has room.
// Synchronous active-low reset clears windows, minimiser, queue and output valid.
`timescale 1ns / 1ps

module kmer_minimizer_bucketing_unit #(
  parameter int KMER_LEN    = 31,
  parameter int MINI_LEN    = 13,
  parameter int BUCKET_BITS = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  kmb_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output kmb_pkg::out_item_t out_item
);

  kmb_pkg::q_stat_t q_stat;
  kmb_pkg::entry_t  push_entry, pop_entry;
  logic             q_push, q_pop;

  // Front end: windows and fill count.
  kmb_front #(
    .KMER_LEN (KMER_LEN),
    .MINI_LEN (MINI_LEN)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_entry  (push_entry)
  );

  // Queue between the two halves.
  kmb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_entry),
    .pop       (q_pop),
    .pop_data  (pop_entry),
    .stat      (q_stat)
  );

  // Back end: minimiser tracking and results.
  kmb_back #(
    .KMER_LEN    (KMER_LEN),
    .MINI_LEN    (MINI_LEN),
    .BUCKET_BITS (BUCKET_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_data    (pop_entry),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// ===== src/kmb_front.sv =====
// Front end: takes input requests, keeps the rolling k-mer and m-mer windows
// and the fill count, and queues every k-mer that yields a result. Uses kmb_pkg.
`timescale 1ns / 1ps

module kmb_front #(
  parameter int KMER_LEN = 31,
  parameter int MINI_LEN = 13
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  kmb_pkg::in_item_t in_item,
  input  kmb_pkg::q_stat_t  q_stat,
  output logic              q_push,
  output kmb_pkg::entry_t   q_entry
);

  localparam int KW = 2 * KMER_LEN;
  localparam int MW = 2 * MINI_LEN;
  localparam int CW = $clog2(KMER_LEN + 1);

  logic [KW-1:0] fwd_win_r, fwd_win_nxt, rc_win_r, rc_win_nxt;
  logic [MW-1:0] fwd_mm_r, fwd_mm_nxt, rc_mm_r, rc_mm_nxt;
  logic [CW-1:0] fill_r, fill_nxt, fill_inc;
  logic [1:0]    code, comp;
  logic          accept, produce, first;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;
  assign code     = in_item.symbol[2:1];
  assign comp     = code ^ 2'b10;

  // Shift the new base into all four windows.
  assign fwd_win_nxt = {fwd_win_r[KW-3:0], code};
  assign rc_win_nxt  = {comp, rc_win_r[KW-1:2]};
  assign fwd_mm_nxt  = {fwd_mm_r[MW-3:0], code};
  assign rc_mm_nxt   = {comp, rc_mm_r[MW-1:2]};

  // Count bases of the read; the window becomes complete on reaching KMER_LEN.
  always_comb begin
    fill_inc = CW'(fill_r + 1'b1);
    if (fill_r < CW'(KMER_LEN)) begin
      first    = (fill_inc == CW'(KMER_LEN));
      produce  = first;
      fill_nxt = fill_inc;
    end else begin
      first    = 1'b0;
      produce  = 1'b1;
      fill_nxt = fill_r;
    end
    if (in_item.read_end) begin
      fill_nxt = '0;
    end
  end

  assign q_push           = accept && produce;
  assign q_entry.fwd_win  = 64'(fwd_win_nxt);
  assign q_entry.rc_win   = 64'(rc_win_nxt);
  assign q_entry.fwd_mmer = 64'(fwd_mm_nxt);
  assign q_entry.rc_mmer  = 64'(rc_mm_nxt);
  assign q_entry.first    = first;
  assign q_entry.last     = in_item.read_end;

  // Window and count registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_win_r <= '0;
      rc_win_r  <= '0;
      fwd_mm_r  <= '0;
      rc_mm_r   <= '0;
      fill_r    <= '0;
    end else if (accept) begin
      fwd_win_r <= fwd_win_nxt;
      rc_win_r  <= rc_win_nxt;
      fwd_mm_r  <= fwd_mm_nxt;
      rc_mm_r   <= rc_mm_nxt;
      fill_r    <= fill_nxt;
    end
  end

endmodule

// ===== src/kmb_queue.sv =====
// Short first-in first-out queue of k-mer entries between front and back.
// Uses kmb_pkg for the entry type and the depth.
`timescale 1ns / 1ps

module kmb_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  kmb_pkg::entry_t   push_data,
  input  logic              pop,
  output kmb_pkg::entry_t   pop_data,
  output kmb_pkg::q_stat_t  stat
);

  kmb_pkg::entry_t          mem_r [kmb_pkg::QDEPTH];
  logic [kmb_pkg::QAW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [kmb_pkg::QAW:0]    count_r;
  logic                     do_wr, do_rd;

  assign stat.full      = (count_r == (kmb_pkg::QAW + 1)'(kmb_pkg::QDEPTH));
  assign stat.not_empty = (count_r != '0);
  assign do_wr          = push && !stat.full;
  assign do_rd          = pop && stat.not_empty;
  assign pop_data       = mem_r[rd_ptr_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= kmb_pkg::QAW'(wr_ptr_r + 1'b1);
      end
      if (do_rd) begin
        rd_ptr_r <= kmb_pkg::QAW'(rd_ptr_r + 1'b1);
      end
      if (do_wr && !do_rd) begin
        count_r <= (kmb_pkg::QAW + 1)'(count_r + 1'b1);
      end else if (do_rd && !do_wr) begin
        count_r <= (kmb_pkg::QAW + 1)'(count_r - 1'b1);
      end
    end
  end

endmodule

// ===== src/kmb_hash.sv =====
// Iterative 64-bit multiply hash: two rounds of xor-shift and multiply, each
// multiply built from three 32x32 partial products. Uses kmb_pkg.
`timescale 1ns / 1ps

module kmb_hash (
  input  logic                clk,
  input  logic                rst_n,
  input  kmb_pkg::hash_req_t  req,
  output kmb_pkg::hash_rsp_t  rsp
);

  logic [63:0] a_r, a_nxt, acc_r, acc_nxt, prod_r, prod_nxt, x;
  logic [31:0] op_a, op_b, hi_sum;
  logic [1:0]  ph_r, ph_nxt;
  logic        rnd_r, rnd_nxt, busy_r, busy_nxt, done_r, done_nxt;

  assign rsp.done  = done_r;
  assign rsp.value = a_r;

  // One partial product per cycle, operands picked by the phase.
  always_comb begin
    op_a     = (ph_r == 2'd1) ? a_r[63:32] : a_r[31:0];
    op_b     = (ph_r == 2'd2) ? kmb_pkg::MIX_MUL_HI : kmb_pkg::MIX_MUL_LO;
    prod_nxt = 64'(op_a) * 64'(op_b);
  end

  // Phase sequencing and accumulation.
  always_comb begin
    a_nxt    = a_r;
    acc_nxt  = acc_r;
    ph_nxt   = ph_r;
    rnd_nxt  = rnd_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    hi_sum   = 32'(acc_r[63:32] + prod_r[31:0]);
    x        = {hi_sum, acc_r[31:0]};
    if (req.start) begin
      a_nxt    = req.key ^ (req.key >> 32);
      ph_nxt   = 2'd0;
      rnd_nxt  = 1'b0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      ph_nxt = 2'(ph_r + 1'b1);
      case (ph_r)
        2'd1: acc_nxt = prod_r;
        2'd2: acc_nxt = {hi_sum, acc_r[31:0]};
        2'd3: begin
          a_nxt   = x ^ (x >> 32);
          rnd_nxt = 1'b1;
          if (rnd_r) begin
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
          end
        end
        default: acc_nxt = acc_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    a_r    <= a_nxt;
    acc_r  <= acc_nxt;
    prod_r <= prod_nxt;
    if (!rst_n) begin
      ph_r   <= '0;
      rnd_r  <= 1'b0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      ph_r   <= ph_nxt;
      rnd_r  <= rnd_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

endmodule

// ===== src/kmb_back.sv =====
// Back end: pops k-mer entries, tracks the minimiser with the hash unit, rescans
// the window when needed, mixes the bucket index and holds the output register.
// Uses kmb_pkg and kmb_hash.
`timescale 1ns / 1ps

module kmb_back #(
  parameter int KMER_LEN    = 31,
  parameter int MINI_LEN    = 13,
  parameter int BUCKET_BITS = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  input  kmb_pkg::q_stat_t   q_stat,
  input  kmb_pkg::entry_t    q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output kmb_pkg::out_item_t out_item
);

  localparam int MW   = 2 * MINI_LEN;
  localparam int SPAN = (KMER_LEN >= MINI_LEN) ? KMER_LEN - MINI_LEN : 0;
  localparam logic [kmb_pkg::BUCKET_W-1:0] BUCKET_MASK =
    (BUCKET_BITS >= kmb_pkg::BUCKET_W) ? '1
                                       : kmb_pkg::BUCKET_W'((64'd1 << BUCKET_BITS) - 1);

  localparam logic [2:0] ST_IDLE        = 3'd0;
  localparam logic [2:0] ST_SCAN_LOAD   = 3'd1;
  localparam logic [2:0] ST_SCAN_WAIT   = 3'd2;
  localparam logic [2:0] ST_STEADY_WAIT = 3'd3;
  localparam logic [2:0] ST_BUCKET      = 3'd4;
  localparam logic [2:0] ST_EMIT        = 3'd5;

  logic [2:0]                   st_r, st_nxt;
  kmb_pkg::entry_t              ent_r, ent_nxt;
  logic [63:0]                  scan_r, scan_nxt;
  logic [kmb_pkg::OFF_W-1:0]    idx_r, idx_nxt, off_r, off_nxt;
  logic [MW-1:0]                cand_r, cand_nxt, best_mm_r, best_mm_nxt;
  logic [63:0]                  best_hash_r, best_hash_nxt, bk_r, bk_nxt;
  logic [1:0]                   bstep_r, bstep_nxt;
  logic [kmb_pkg::BUCKET_W-1:0] bucket_r, bucket_nxt;
  logic                         group_r, group_nxt, out_valid_r, out_valid_nxt;
  kmb_pkg::out_item_t           out_item_r, out_item_nxt;
  kmb_pkg::hash_req_t           hreq;
  kmb_pkg::hash_rsp_t           hrsp;
  logic [MW-1:0]                slice, steady_fm, steady_rm;
  logic [63:0]                  best_mm64, t;

  kmb_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (hreq),
    .rsp   (hrsp)
  );

  // Reverse complement of one m-mer: reverse the bases and flip bit 1 of each.
  function automatic logic [MW-1:0] rev_comp(input logic [MW-1:0] x);
    logic [MW-1:0] r;
    r = '0;
    for (int i = 0; i < MINI_LEN; i++) begin
      r[2*i +: 2] = x[2*(MINI_LEN-1-i) +: 2] ^ 2'b10;
    end
    return r;
  endfunction

  function automatic logic [MW-1:0] canon(input logic [MW-1:0] m);
    logic [MW-1:0] r;
    r = rev_comp(m);
    return (r < m) ? r : m;
  endfunction

  assign slice     = scan_r[2*SPAN +: MW];
  assign steady_fm = q_data.fwd_mmer[MW-1:0];
  assign steady_rm = q_data.rc_mmer[MW-1:0];
  assign best_mm64 = 64'(best_mm_r);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Sequencer for the minimiser, rescan and bucket steps.
  always_comb begin
    st_nxt        = st_r;
    ent_nxt       = ent_r;
    scan_nxt      = scan_r;
    idx_nxt       = idx_r;
    off_nxt       = off_r;
    cand_nxt      = cand_r;
    best_mm_nxt   = best_mm_r;
    best_hash_nxt = best_hash_r;
    bk_nxt        = bk_r;
    bstep_nxt     = bstep_r;
    bucket_nxt    = bucket_r;
    group_nxt     = group_r;
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r && out_stall;
    q_pop         = 1'b0;
    hreq.start    = 1'b0;
    hreq.key      = 64'(cand_r);
    t             = '0;
    unique case (st_r)
      ST_IDLE: begin
        if (q_stat.not_empty) begin
          q_pop   = 1'b1;
          ent_nxt = q_data;
          if (q_data.first) begin
            scan_nxt  = q_data.fwd_win;
            idx_nxt   = '0;
            group_nxt = 1'b1;
            st_nxt    = ST_SCAN_LOAD;
          end else begin
            cand_nxt   = (steady_fm < steady_rm) ? steady_fm : steady_rm;
            hreq.start = 1'b1;
            hreq.key   = 64'(cand_nxt);
            st_nxt     = ST_STEADY_WAIT;
          end
        end
      end
      ST_SCAN_LOAD: begin
        cand_nxt   = canon(slice);
        hreq.start = 1'b1;
        hreq.key   = 64'(cand_nxt);
        scan_nxt   = scan_r << 2;
        st_nxt     = ST_SCAN_WAIT;
      end
      ST_SCAN_WAIT: begin
        if (hrsp.done) begin
          // Strict compare keeps the leftmost m-mer on ties.
          if (idx_r == '0 || hrsp.value < best_hash_r) begin
            best_hash_nxt = hrsp.value;
            best_mm_nxt   = cand_r;
            off_nxt       = idx_r;
          end
          if (idx_r == kmb_pkg::OFF_W'(SPAN)) begin
            bk_nxt    = best_hash_nxt;
            bstep_nxt = '0;
            st_nxt    = ST_BUCKET;
          end else begin
            idx_nxt = kmb_pkg::OFF_W'(idx_r + 1'b1);
            st_nxt  = ST_SCAN_LOAD;
          end
        end
      end
      ST_STEADY_WAIT: begin
        if (hrsp.done) begin
          if (hrsp.value < best_hash_r) begin
            best_hash_nxt = hrsp.value;
            best_mm_nxt   = cand_r;
            off_nxt       = kmb_pkg::OFF_W'(SPAN);
            group_nxt     = 1'b1;
            bk_nxt        = hrsp.value;
            bstep_nxt     = '0;
            st_nxt        = ST_BUCKET;
          end else if (off_r == '0) begin
            // The minimiser has slid out of the window.
            group_nxt = 1'b1;
            scan_nxt  = ent_r.fwd_win;
            idx_nxt   = '0;
            st_nxt    = ST_SCAN_LOAD;
          end else begin
            off_nxt   = kmb_pkg::OFF_W'(off_r - 1'b1);
            group_nxt = 1'b0;
            st_nxt    = ST_EMIT;
          end
        end
      end
      ST_BUCKET: begin
        bstep_nxt = 2'(bstep_r + 1'b1);
        case (bstep_r)
          2'd0: begin
            t      = ~bk_r + (bk_r << 21);
            bk_nxt = t ^ (t >> 24);
          end
          2'd1: begin
            t      = bk_r + (bk_r << 3) + (bk_r << 8);
            bk_nxt = t ^ (t >> 14);
          end
          2'd2: begin
            t      = bk_r + (bk_r << 2) + (bk_r << 4);
            bk_nxt = t ^ (t >> 28);
          end
          default: begin
            t          = bk_r + (bk_r << 31);
            bucket_nxt = t[kmb_pkg::BUCKET_W-1:0] & BUCKET_MASK;
            st_nxt     = ST_EMIT;
          end
        endcase
      end
      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_item_nxt.kmer_fwd     = ent_r.fwd_win[kmb_pkg::KMER_OUT_W-1:0];
          out_item_nxt.kmer_revcomp = ent_r.rc_win[kmb_pkg::KMER_OUT_W-1:0];
          out_item_nxt.bucket       = bucket_r;
          out_item_nxt.minimizer    = best_mm64[kmb_pkg::MINI_OUT_W-1:0];
          out_item_nxt.new_group    = group_r;
          out_item_nxt.last         = ent_r.last;
          out_valid_nxt             = 1'b1;
          st_nxt                    = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    ent_r      <= ent_nxt;
    scan_r     <= scan_nxt;
    idx_r      <= idx_nxt;
    cand_r     <= cand_nxt;
    bk_r       <= bk_nxt;
    bstep_r    <= bstep_nxt;
    bucket_r   <= bucket_nxt;
    group_r    <= group_nxt;
    out_item_r <= out_item_nxt;
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      off_r       <= '0;
      best_mm_r   <= '0;
      best_hash_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      off_r       <= off_nxt;
      best_mm_r   <= best_mm_nxt;
      best_hash_r <= best_hash_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== src/kmb_checker.sv =====
// Port-level checks for the k-mer minimiser bucketing unit, bound to the top level.
// Uses kmb_pkg for the result request type.
`timescale 1ns / 1ps

module kmb_checker #(
  parameter int KMER_LEN = 31
) (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input kmb_pkg::out_item_t out_item
);

  logic expect_first_r;

  // Reverse complement of the forward k-mer in the same packing.
  function automatic logic [kmb_pkg::KMER_OUT_W-1:0] rc_of(
    input logic [kmb_pkg::KMER_OUT_W-1:0] f);
    logic [kmb_pkg::KMER_OUT_W-1:0] r;
    r = '0;
    for (int i = 0; i < kmb_pkg::KMER_OUT_W / 2; i++) begin
      if (i < KMER_LEN) begin
        r[2*i +: 2] = f[2*(KMER_LEN-1-i) +: 2] ^ 2'b10;
      end
    end
    return r;
  endfunction

  // The next result after a read's last one (or after reset) opens a read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_first_r <= 1'b1;
    end else if (out_valid && !out_stall) begin
      expect_first_r <= out_item.last;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result request changed while stalled");

  a_first_group: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && expect_first_r |-> out_item.new_group)
    else $error("first k-mer of a read does not open a group");

  a_revcomp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (KMER_LEN < 32) |-> out_item.kmer_revcomp == rc_of(out_item.kmer_fwd))
    else $error("reverse complement does not match forward k-mer");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind kmer_minimizer_bucketing_unit kmb_checker #(
  .KMER_LEN (KMER_LEN)
) u_kmb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

// ===== tb/sv/kmer_minimizer_bucketing_unit_tb.sv =====
// Self-checking bench for the k-mer minimiser bucketing unit: directed table, then random reads.
// Depends on kmb_pkg and kmer_minimizer_bucketing_unit; carries its own prediction of the stream.
`timescale 1ns / 1ps

module kmer_minimizer_bucketing_unit_tb;

  localparam int KLEN  = 31;
  localparam int MLEN  = 13;
  localparam int BBITS = 20;
  localparam int SPANP = (KLEN >= MLEN) ? KLEN - MLEN : 0;
  localparam logic [63:0] MULT = 64'hD6E8FEB86659FD93;

  // Known k-mers of uniform reads.
  localparam logic [61:0] KM_ALL_A = 62'h0;
  localparam logic [61:0] KM_ALL_T = 62'h2aaaaaaaaaaaaaaa;
  localparam logic [61:0] KM_ALL_G = 62'h3fffffffffffffff;
  localparam logic [61:0] KM_ALL_C = 62'h1555555555555555;
  localparam logic [25:0] MM_ALL_A = 26'h0;
  localparam logic [25:0] MM_ALL_C = 26'h1555555;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  kmb_pkg::in_item_t in_item;
  logic out_valid;
  logic out_stall;
  kmb_pkg::out_item_t out_item;

  kmer_minimizer_bucketing_unit #(
    .KMER_LEN(KLEN), .MINI_LEN(MLEN), .BUCKET_BITS(BBITS)
  ) dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  // Predictor state.
  logic [63:0] p_fwd, p_rc, p_fm, p_rm, p_bhash, p_bmmer;
  int unsigned p_boff, p_fill;

  kmb_pkg::out_item_t kmer_queue[$];
  int errors;
  int results_seen;
  int reads_done;
  int items_sent;
  bit hold_off;

  // Stimulus table: symbol, read_end, and where obvious the expected k-mer and minimiser.
  typedef struct {
    logic [6:0]  sym;
    logic        rend;
    bit          chk;
    logic [61:0] fwd;
    logic [61:0] rc;
    logic [25:0] mini;
  } stim_row_t;

  stim_row_t stim_tbl[$];

  function automatic logic [63:0] lmask(int unsigned bits);
    return bits >= 64 ? '1 : ((64'd1 << bits) - 64'd1);
  endfunction

  function automatic logic [63:0] revcomp(logic [63:0] x, int unsigned n);
    logic [63:0] v;
    logic [63:0] r;
    v = x ^ 64'haaaaaaaaaaaaaaaa;
    r = '0;
    for (int i = 0; i < 32; i++) r[2*i +: 2] = v[62-2*i +: 2];
    return r >> (64 - 2 * n);
  endfunction

  function automatic logic [63:0] mix64(logic [63:0] x);
    x = ((x >> 32) ^ x) * MULT;
    x = ((x >> 32) ^ x) * MULT;
    return (x >> 32) ^ x;
  endfunction

  function automatic logic [63:0] shift_mix(logic [63:0] k);
    k = (~k) + (k << 21);
    k = k ^ (k >> 24);
    k = (k + (k << 3)) + (k << 8);
    k = k ^ (k >> 14);
    k = (k + (k << 2)) + (k << 4);
    k = k ^ (k >> 28);
    k = k + (k << 31);
    return k;
  endfunction

  function automatic logic [63:0] canonical(logic [63:0] m);
    logic [63:0] r;
    r = revcomp(m, MLEN);
    return r < m ? r : m;
  endfunction

  task automatic rescan_window();
    logic [63:0] c, h;
    for (int j = 0; j <= SPANP; j++) begin
      c = canonical((p_fwd >> (2 * (SPANP - j))) & lmask(2 * MLEN));
      h = mix64(c);
      if (j == 0 || h < p_bhash) begin
        p_bhash = h;
        p_bmmer = c;
        p_boff = j;
      end
    end
  endtask

  // Advance the predicted state by one base and queue any k-mer it yields.
  task automatic predict_base(kmb_pkg::in_item_t it);
    logic [63:0] code, comp, c, h;
    bit grp, prod;
    kmb_pkg::out_item_t e;
    code = 64'(it.symbol[2:1]);
    comp = code ^ 64'd2;
    grp = 0;
    prod = 0;
    p_fwd = ((p_fwd << 2) | code) & lmask(2 * KLEN);
    p_rc = (p_rc >> 2) | (comp << (2 * KLEN - 2));
    p_fm = ((p_fm << 2) | code) & lmask(2 * MLEN);
    p_rm = (p_rm >> 2) | (comp << (2 * MLEN - 2));
    if (p_fill < KLEN) begin
      p_fill++;
      if (p_fill == KLEN) begin
        rescan_window();
        grp = 1;
        prod = 1;
      end
    end else begin
      c = p_fm < p_rm ? p_fm : p_rm;
      h = mix64(c);
      if (h < p_bhash) begin
        p_bhash = h;
        p_bmmer = c;
        p_boff = SPANP;
        grp = 1;
      end else if (p_boff == 0) begin
        rescan_window();
        grp = 1;
      end else begin
        p_boff--;
      end
      prod = 1;
    end
    if (prod) begin
      e.kmer_fwd = p_fwd[61:0];
      e.kmer_revcomp = p_rc[61:0];
      e.bucket = 20'(shift_mix(p_bhash) & lmask(BBITS));
      e.minimizer = p_bmmer[25:0];
      e.new_group = grp;
      e.last = it.read_end;
      kmer_queue = {kmer_queue, e};
    end
    if (it.read_end) begin
      p_fill = 0;
      reads_done++;
    end
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic add_row(logic [6:0] sym, logic rend, bit chk,
                         logic [61:0] fwd, logic [61:0] rc, logic [25:0] mini);
    stim_row_t row;
    row.sym = sym;
    row.rend = rend;
    row.chk = chk;
    row.fwd = fwd;
    row.rc = rc;
    row.mini = mini;
    stim_tbl = {stim_tbl, row};
  endtask

  // Compare the newest predicted k-mer with the values typed into the table.
  task automatic check_row(stim_row_t row);
    kmb_pkg::out_item_t e;
    if (kmer_queue.size() == 0) begin
      report_mismatch("directed row gave no k-mer", 64'd0, 64'd1);
    end else begin
      e = kmer_queue[$];
      if (e.kmer_fwd !== row.fwd) report_mismatch("directed kmer_fwd", e.kmer_fwd, row.fwd);
      if (e.kmer_revcomp !== row.rc)
        report_mismatch("directed kmer_revcomp", e.kmer_revcomp, row.rc);
      if (e.minimizer !== row.mini)
        report_mismatch("directed minimizer", e.minimizer, row.mini);
    end
  endtask

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

  // Receiver: random stall pattern, with a long hold-off on request.
  initial begin
    int mode;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) out_stall <= 1'b1;
      else begin
        mode = (results_seen / 300) % 3;
        if (mode == 0) out_stall <= 1'b0;
        else if (mode == 1) out_stall <= ($urandom_range(0, 3) == 0);
        else out_stall <= ($urandom_range(0, 1) == 0);
      end
    end
  end

  // Result checker.
  always @(posedge clk) begin
    kmb_pkg::out_item_t w;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (kmer_queue.size() == 0) begin
        report_mismatch("unexpected result", 64'd1, 64'd0);
      end else begin
        w = kmer_queue.pop_front();
        if (out_item.kmer_fwd !== w.kmer_fwd)
          report_mismatch("kmer_fwd", out_item.kmer_fwd, w.kmer_fwd);
        if (out_item.kmer_revcomp !== w.kmer_revcomp)
          report_mismatch("kmer_revcomp", out_item.kmer_revcomp, w.kmer_revcomp);
        if (out_item.bucket !== w.bucket)
          report_mismatch("bucket", out_item.bucket, w.bucket);
        if (out_item.minimizer !== w.minimizer)
          report_mismatch("minimizer", out_item.minimizer, w.minimizer);
        if (out_item.new_group !== w.new_group)
          report_mismatch("new_group", out_item.new_group, w.new_group);
        if (out_item.last !== w.last)
          report_mismatch("last", out_item.last, w.last);
      end
    end
  end

  // Offer one request and hold it until accepted.
  task automatic send_base(logic [6:0] sym, logic rend);
    kmb_pkg::in_item_t it;
    it.symbol = sym;
    it.read_end = rend;
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    items_sent++;
    predict_base(it);
  endtask

  task automatic idle_gap(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Send one read of random content, occasionally with non-nucleotide characters.
  task automatic send_read(int len, bit bursty);
    logic [6:0] s;
    logic [6:0] acgt[4];
    acgt = '{7'h41, 7'h43, 7'h54, 7'h47};
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) s = 7'($urandom_range(0, 127));
      else s = acgt[$urandom_range(0, 3)] | ($urandom_range(0, 1) ? 7'h20 : 7'h00);
      send_base(s, i == len - 1);
      if (bursty && $urandom_range(0, 7) == 0) idle_gap($urandom_range(1, 6));
    end
  endtask

  initial begin
    int wait_cnt;
    int len;
    errors = 0;
    results_seen = 0;
    reads_done = 0;
    items_sent = 0;
    hold_off = 0;
    p_fwd = 0; p_rc = 0; p_fm = 0; p_rm = 0;
    p_bhash = 0; p_bmmer = 0; p_boff = 0; p_fill = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_item <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: short read, then all-A read, then all-ones characters, then mixed.
    for (int i = 0; i < 3; i++) add_row(7'h43, i == 2, 1'b0, '0, '0, '0);
    for (int i = 0; i < 32; i++)
      add_row(7'h00, i == 31, i >= KLEN - 1, KM_ALL_A, KM_ALL_T, MM_ALL_A);
    for (int i = 0; i < 33; i++)
      add_row(7'h7f, i == 32, i >= KLEN - 1, KM_ALL_G, KM_ALL_C, MM_ALL_C);
    for (int i = 0; i < 34; i++) add_row(7'(i * 37 + 5), i == 33, 1'b0, '0, '0, '0);
    foreach (stim_tbl[i]) begin
      send_base(stim_tbl[i].sym, stim_tbl[i].rend);
      if (stim_tbl[i].chk) check_row(stim_tbl[i]);
    end
    in_valid <= 1'b0;

    // Random reads, mostly long enough to produce k-mers.
    while (items_sent < 2000) begin
      if (reads_done == 20) begin
        // Receiver holds off while the sender keeps offering requests.
        hold_off = 1;
        fork
          send_read(60, 0);
          begin
            repeat (400) @(posedge clk);
            hold_off = 0;
          end
        join
      end else if (reads_done % 15 == 0) begin
        // Sender pauses until every expected k-mer has come.
        in_valid <= 1'b0;
        while (kmer_queue.size() != 0) @(posedge clk);
        send_read($urandom_range(31, 70), 1);
      end else begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 30) : $urandom_range(31, 90);
        send_read(len, $urandom_range(0, 1));
      end
      if ($urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 20));
    end
    in_valid <= 1'b0;

    wait_cnt = 0;
    while (kmer_queue.size() != 0 && wait_cnt < 200000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (300) @(posedge clk);
    if (kmer_queue.size() != 0) begin
      report_mismatch("k-mers never arrived", 64'(kmer_queue.size()), 64'd0);
    end
    $display("Covered %0d bases in %0d reads giving %0d k-mer results, with short reads,",
             items_sent, reads_done, results_seen);
    $display("odd characters, a long output hold-off and idle pauses on the input.");
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
